/* hw/rtl/biq_pkg.sv */
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants of the biquad section: register map, mode
// codes, configuration bundle, datapath command bundle and controller states.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int COEF_W     = 20;
  localparam int WEIGHT_W   = 17;
  localparam int MODE_W     = 2;
  localparam int HIST_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int MIX_FRAC   = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FORM_MODE  = 3'd6;

  // filter forms
  localparam logic [MODE_W-1:0] MODE_DF1     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DF1_MIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DF2T    = 2'd2;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [WEIGHT_W-1:0]      weight;
    logic [MODE_W-1:0]        mode;
  } biq_cfg_t;

  typedef enum logic [2:0] {
    MA_B0, MA_B1, MA_B2, MA_A1, MA_A2, MA_W, MA_IW
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_X, MB_HA, MB_HB, MB_Y1, MB_Y2, MB_YD
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOAD_RND, ACC_LOAD_MIX, ACC_LOAD_HB,
    ACC_ADD, ACC_SUB, ACC_ADD_HA
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_FILT, OUT_MIX, OUT_DF2
  } out_src_t;

  typedef struct packed {
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    logic       mul_en;
    acc_op_t    acc_op;
    logic       df1_upd;
    logic       yd_load;
    logic       ha_wr;
    logic       hb_wr;
    out_src_t   out_src;
  } biq_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D1_B0, ST_D1_B1, ST_D1_B2, ST_D1_A1, ST_D1_A2, ST_D1_ACC, ST_D1_FIN,
    ST_MX_W, ST_MX_IW, ST_MX_ACC, ST_MX_FIN,
    ST_D2_B0, ST_D2_B1, ST_D2_HA, ST_D2_Y, ST_D2_A1, ST_D2_SA1, ST_D2_WHA,
    ST_D2_SA2, ST_D2_FIN
  } biq_state_t;

endpackage

/* hw/rtl/biq_cfg_regs.sv */
// ----------------------------------------------------------------------------
// biq_cfg_regs
// Configuration register bank: coefficients, crossfade weight and form.
// ----------------------------------------------------------------------------
module biq_cfg_regs
  import biq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output biq_cfg_t              cfg
);

  biq_cfg_t cfg_r;
  biq_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_B0:    cfg_nxt.b0     = signed'(cfg_wdata[COEF_W-1:0]);
        REG_COEF_B1:    cfg_nxt.b1     = signed'(cfg_wdata[COEF_W-1:0]);
        REG_COEF_B2:    cfg_nxt.b2     = signed'(cfg_wdata[COEF_W-1:0]);
        REG_COEF_A1:    cfg_nxt.a1     = signed'(cfg_wdata[COEF_W-1:0]);
        REG_COEF_A2:    cfg_nxt.a2     = signed'(cfg_wdata[COEF_W-1:0]);
        REG_MIX_WEIGHT: cfg_nxt.weight = cfg_wdata[WEIGHT_W-1:0];
        REG_FORM_MODE:  cfg_nxt.mode   = cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0     <= COEF_ONE;
      cfg_r.b1     <= '0;
      cfg_r.b2     <= '0;
      cfg_r.a1     <= '0;
      cfg_r.a2     <= '0;
      cfg_r.weight <= WEIGHT_ONE;
      cfg_r.mode   <= MODE_DF1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/biq_ctrl.sv */
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer: walks one sample through the shared multiply-accumulate unit,
// at most one product per cycle, and owns the request handshakes.
// ----------------------------------------------------------------------------
module biq_ctrl
  import biq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] form_mode,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output biq_cmd_t          cmd
);

  biq_state_t state_r;
  biq_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // the result slot may be refilled in the cycle it is drained
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (form_mode == MODE_DF2T) ? ST_D2_B0 : ST_D1_B0;
      end
      ST_D1_B0:  state_nxt = ST_D1_B1;
      ST_D1_B1:  state_nxt = ST_D1_B2;
      ST_D1_B2:  state_nxt = ST_D1_A1;
      ST_D1_A1:  state_nxt = ST_D1_A2;
      ST_D1_A2:  state_nxt = ST_D1_ACC;
      ST_D1_ACC: state_nxt = ST_D1_FIN;
      ST_D1_FIN: begin
        if (form_mode == MODE_DF1_MIX) state_nxt = ST_MX_W;
        else if (out_free)             state_nxt = ST_IDLE;
      end
      ST_MX_W:   state_nxt = ST_MX_IW;
      ST_MX_IW:  state_nxt = ST_MX_ACC;
      ST_MX_ACC: state_nxt = ST_MX_FIN;
      ST_MX_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_D2_B0:  state_nxt = ST_D2_B1;
      ST_D2_B1:  state_nxt = ST_D2_HA;
      ST_D2_HA:  state_nxt = ST_D2_Y;
      ST_D2_Y:   state_nxt = ST_D2_A1;
      ST_D2_A1:  state_nxt = ST_D2_SA1;
      ST_D2_SA1: state_nxt = ST_D2_WHA;
      ST_D2_WHA: state_nxt = ST_D2_SA2;
      ST_D2_SA2: state_nxt = ST_D2_FIN;
      ST_D2_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.mul_a   = MA_B0;
    cmd.mul_b   = MB_X;
    cmd.mul_en  = 1'b0;
    cmd.acc_op  = ACC_HOLD;
    cmd.df1_upd = 1'b0;
    cmd.yd_load = 1'b0;
    cmd.ha_wr   = 1'b0;
    cmd.hb_wr   = 1'b0;
    cmd.out_src = OUT_NONE;
    case (state_r)
      ST_D1_B0: begin
        cmd.mul_a  = MA_B0;
        cmd.mul_b  = MB_X;
        cmd.mul_en = 1'b1;
      end
      ST_D1_B1: begin
        cmd.mul_a  = MA_B1;
        cmd.mul_b  = MB_HA;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD_RND;
      end
      ST_D1_B2: begin
        cmd.mul_a  = MA_B2;
        cmd.mul_b  = MB_HB;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_ADD;
      end
      ST_D1_A1: begin
        cmd.mul_a  = MA_A1;
        cmd.mul_b  = MB_Y1;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_ADD;
      end
      ST_D1_A2: begin
        cmd.mul_a  = MA_A2;
        cmd.mul_b  = MB_Y2;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_SUB;
      end
      ST_D1_ACC: cmd.acc_op = ACC_SUB;
      ST_D1_FIN: begin
        if (form_mode == MODE_DF1_MIX) begin
          cmd.df1_upd = 1'b1;
        end else if (out_free) begin
          cmd.df1_upd = 1'b1;
          cmd.out_src = OUT_FILT;
        end
      end
      ST_MX_W: begin
        // y1 now holds the saturated filter output
        cmd.mul_a  = MA_W;
        cmd.mul_b  = MB_Y1;
        cmd.mul_en = 1'b1;
      end
      ST_MX_IW: begin
        cmd.mul_a  = MA_IW;
        cmd.mul_b  = MB_X;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD_MIX;
      end
      ST_MX_ACC: cmd.acc_op = ACC_ADD;
      ST_MX_FIN: begin
        if (out_free) cmd.out_src = OUT_MIX;
      end
      ST_D2_B0: begin
        cmd.mul_a  = MA_B0;
        cmd.mul_b  = MB_X;
        cmd.mul_en = 1'b1;
      end
      ST_D2_B1: begin
        cmd.mul_a  = MA_B1;
        cmd.mul_b  = MB_X;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD_RND;
      end
      ST_D2_HA: cmd.acc_op = ACC_ADD_HA;
      ST_D2_Y: begin
        // b1*x is still held in the product register
        cmd.yd_load = 1'b1;
        cmd.acc_op  = ACC_LOAD_HB;
      end
      ST_D2_A1: begin
        cmd.mul_a  = MA_A1;
        cmd.mul_b  = MB_YD;
        cmd.mul_en = 1'b1;
      end
      ST_D2_SA1: begin
        cmd.mul_a  = MA_B2;
        cmd.mul_b  = MB_X;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_SUB;
      end
      ST_D2_WHA: begin
        cmd.ha_wr  = 1'b1;
        cmd.mul_a  = MA_A2;
        cmd.mul_b  = MB_YD;
        cmd.mul_en = 1'b1;
        cmd.acc_op = ACC_LOAD;
      end
      ST_D2_SA2: cmd.acc_op = ACC_SUB;
      ST_D2_FIN: begin
        if (out_free) begin
          cmd.hb_wr   = 1'b1;
          cmd.out_src = OUT_DF2;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (cmd.out_src != OUT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/biq_dpath.sv */
// ----------------------------------------------------------------------------
// biq_dpath
// Datapath: one registered 20x32 signed multiplier, a wide accumulator,
// filter history, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module biq_dpath
  import biq_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          x_load,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  biq_cfg_t                      cfg,
  input  biq_cmd_t                      cmd,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int PROD_W = COEF_W + HIST_W;
  localparam int ACC_W  = PROD_W + 4;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MIX_HALF = ACC_W'(1) << (MIX_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SMP_MAX  =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMP_MIN  = ~SMP_MAX;
  localparam logic signed [ACC_W-1:0] HST_MAX  =
    ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] HST_MIN  = ~HST_MAX;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    if (v > SMP_MAX)      return SMP_MAX[SAMPLE_BITS-1:0];
    else if (v < SMP_MIN) return SMP_MIN[SAMPLE_BITS-1:0];
    else                  return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [HIST_W-1:0] sat_hst(
    input logic signed [ACC_W-1:0] v
  );
    if (v > HST_MAX)      return HST_MAX[HIST_W-1:0];
    else if (v < HST_MIN) return HST_MIN[HIST_W-1:0];
    else                  return v[HIST_W-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [HIST_W-1:0]      hist_a_r, hist_a_nxt;
  logic signed [HIST_W-1:0]      hist_b_r, hist_b_nxt;
  logic signed [SAMPLE_BITS-1:0] y1_r, y1_nxt;
  logic signed [SAMPLE_BITS-1:0] y2_r, y2_nxt;
  logic signed [SAMPLE_BITS-1:0] yd_r;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;

  logic [WEIGHT_W-1:0]           w_clip;
  logic [WEIGHT_W-1:0]           w_inv;
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [HIST_W-1:0]      mul_b;
  logic signed [ACC_W-1:0]       acc_prod;
  logic signed [SAMPLE_BITS-1:0] filt_res;
  logic signed [SAMPLE_BITS-1:0] mix_res;
  logic signed [HIST_W-1:0]      hist_res;

  // weights above one act as one
  assign w_clip = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
  assign w_inv  = WEIGHT_ONE - w_clip;

  always_comb begin
    case (cmd.mul_a)
      MA_B0:   mul_a = cfg.b0;
      MA_B1:   mul_a = cfg.b1;
      MA_B2:   mul_a = cfg.b2;
      MA_A1:   mul_a = cfg.a1;
      MA_A2:   mul_a = cfg.a2;
      MA_W:    mul_a = signed'({{(COEF_W - WEIGHT_W){1'b0}}, w_clip});
      MA_IW:   mul_a = signed'({{(COEF_W - WEIGHT_W){1'b0}}, w_inv});
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.mul_b)
      MB_X:    mul_b = HIST_W'(x_r);
      MB_HA:   mul_b = hist_a_r;
      MB_HB:   mul_b = hist_b_r;
      MB_Y1:   mul_b = HIST_W'(y1_r);
      MB_Y2:   mul_b = HIST_W'(y2_r);
      MB_YD:   mul_b = HIST_W'(yd_r);
      default: mul_b = '0;
    endcase
  end

  assign prod_nxt = cmd.mul_en ? mul_a * mul_b : prod_r;
  assign acc_prod = ACC_W'(prod_r);

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:     acc_nxt = acc_prod;
      ACC_LOAD_RND: acc_nxt = acc_prod + RND_HALF;
      ACC_LOAD_MIX: acc_nxt = acc_prod + MIX_HALF;
      ACC_LOAD_HB:  acc_nxt = acc_prod + ACC_W'(hist_b_r);
      ACC_ADD:      acc_nxt = acc_r + acc_prod;
      ACC_SUB:      acc_nxt = acc_r - acc_prod;
      ACC_ADD_HA:   acc_nxt = acc_r + ACC_W'(hist_a_r);
      default:      acc_nxt = acc_r;
    endcase
  end

  // arithmetic shift is a floor, the half lsb was added at load
  assign filt_res = sat_smp(acc_r >>> COEF_FRAC_BITS);
  assign mix_res  = sat_smp(acc_r >>> MIX_FRAC);
  assign hist_res = sat_hst(acc_r);

  always_comb begin
    hist_a_nxt = hist_a_r;
    hist_b_nxt = hist_b_r;
    y1_nxt     = y1_r;
    y2_nxt     = y2_r;
    if (cmd.df1_upd) begin
      hist_b_nxt = hist_a_r;
      hist_a_nxt = HIST_W'(x_r);
      y2_nxt     = y1_r;
      y1_nxt     = filt_res;
    end
    if (cmd.ha_wr) hist_a_nxt = hist_res;
    if (cmd.hb_wr) hist_b_nxt = hist_res;
  end

  always_comb begin
    case (cmd.out_src)
      OUT_FILT: out_nxt = filt_res;
      OUT_MIX:  out_nxt = mix_res;
      OUT_DF2:  out_nxt = yd_r;
      default:  out_nxt = out_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_a_r <= '0;
      hist_b_r <= '0;
      y1_r     <= '0;
      y2_r     <= '0;
    end else begin
      hist_a_r <= hist_a_nxt;
      hist_b_r <= hist_b_nxt;
      y1_r     <= y1_nxt;
      y2_r     <= y2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (x_load)      x_r  <= sample_in;
    if (cmd.yd_load) yd_r <= filt_res;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign sample_out = out_r;

endmodule

/* hw/rtl/biquad_iir_filter_core.sv */
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Second-order IIR section, direct form 1, crossfaded form 1 or form 2
// transposed, on a stream of signed samples.
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid/in_ready/in_sample_in: one request per sample
//   result channel out_valid/out_ready/out_sample_out: one result per sample
//   config port    cfg_wr_en/cfg_index/cfg_wdata: single-cycle writes, only
//                  while no sample is in flight; unknown indexes are dropped
// sequencing
//   one shared 20x32 multiplier does at most one product per cycle; each
//   form steps a sample through its own sequencer states in turn, and its
//   last state holds while an untaken result sits in the output register
//   one sample is worked on at a time
// reset
//   rst_n low clears history, loads b0 = 1.0, weight = 1.0, direct form 1
// back-pressure
//   a finished result waits in the output register; the next sample is
//   taken and worked on, and its last step holds until the slot drains
// ----------------------------------------------------------------------------
module biquad_iir_filter_core
  import biq_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  biq_cfg_t cfg;
  biq_cmd_t dp_cmd;
  logic     x_load;

  assign x_load = in_valid && in_ready;

  biq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  biq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .form_mode (cfg.mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd)
  );

  biq_dpath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .x_load     (x_load),
    .sample_in  (in_sample_in),
    .cfg        (cfg),
    .cmd        (dp_cmd),
    .sample_out (out_sample_out)
  );

  // the input does not reopen right after a sample is accepted
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("input reopened right after accepting a sample");

  // a result is only written by the last step of a sample
  a_result_while_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    dp_cmd.out_src != OUT_NONE |-> !in_ready
  ) else $error("result written while idle");

  // history shift of form 1 never collides with form 2 state writes
  a_hist_exclusive: assert property (
    @(posedge clk) disable iff (!rst_n)
    dp_cmd.df1_upd |-> !dp_cmd.ha_wr && !dp_cmd.hb_wr
  ) else $error("conflicting history updates");

  // a result is never written over one that has not been taken
  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    dp_cmd.out_src != OUT_NONE |-> !out_valid || out_ready
  ) else $error("pending result overwritten");

endmodule

/* dv/biquad_iir_filter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_core_tb
// Self-checking bench for the biquad section. A bit-exact model of the three
// filter forms runs beside the core. Every accepted sample gets an expected
// output, and each result from the core is checked against the oldest one.
// Both channels idle at random. The registers are rewritten between bursts,
// once the core has drained.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core_tb;
  import biq_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int RANDOM_SAMPLES = 1100;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  biquad_iir_filter_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .COEF_FRAC_BITS(16)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter model: coefficients, weight, form and history
  longint coef_b0 = 65536, coef_b1 = 0, coef_b2 = 0, coef_a1 = 0, coef_a2 = 0;
  logic [WEIGHT_W-1:0] weight_q = WEIGHT_ONE;
  logic [MODE_W-1:0] form_q = MODE_DF1;
  longint hist_a = 0, hist_b = 0, y_prev1 = 0, y_prev2 = 0;

  logic signed [SAMPLE_W-1:0] sample_backlog[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  int samples_queued = 0;
  int samples_taken = 0;
  int mismatch_count = 0;
  logic in_fire = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int in_gap = 0;
  int out_stall = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_sample(longint v);
    return clamp(v, -32768, 32767);
  endfunction

  // round half up, then drop the 16 fraction bits
  function automatic longint round_q16(longint acc);
    return (acc + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] biquad_step(logic signed [SAMPLE_W-1:0] xs);
    longint x, y, f, acc, w, mix, next_a;
    x = xs;
    if (form_q == MODE_DF2T) begin
      y = sat_sample(round_q16(coef_b0 * x + hist_a));
      next_a = clamp(coef_b1 * x - coef_a1 * y + hist_b, -64'sd2147483648, 64'sd2147483647);
      hist_b = clamp(coef_b2 * x - coef_a2 * y, -64'sd2147483648, 64'sd2147483647);
      hist_a = next_a;
    end else begin
      acc = coef_b0 * x + coef_b1 * hist_a + coef_b2 * hist_b
          - coef_a1 * y_prev1 - coef_a2 * y_prev2;
      f = sat_sample(round_q16(acc));
      hist_b = hist_a;
      hist_a = x;
      y_prev2 = y_prev1;
      y_prev1 = f;
      y = f;
      if (form_q == MODE_DF1_MIX) begin
        w = (weight_q > WEIGHT_ONE) ? 65536 : weight_q;
        mix = w * f + (65536 - w) * x + 32768;
        y = sat_sample(mix >>> 16);
      end
    end
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom);
    if (r < 8) return 16'(int'($urandom_range(0, 4000)) - 2000);
    if (r == 8) return 16'sh7fff;
    return 16'sh8000;
  endfunction

  function automatic int extreme_coef();
    case ($urandom_range(0, 3))
      0: return -524288;
      1: return 524287;
      2: return 0;
      default: return 65536;
    endcase
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s expected %0d got %0d", what, want, got);
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_backlog.size() > 0) begin
        in_sample_in <= sample_backlog.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 99) < 25) out_stall = pick_gap(1'b0) + 1;
    end
  end

  // monitor: predict on each accepted request, check each result
  always @(posedge clk) begin : monitor
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          note_mismatch("unexpected sample_out, nothing pending:", 0, out_sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) note_mismatch("sample_out", want, out_sample_out);
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(biquad_step(in_sample_in));
        samples_taken++;
      end
    end
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_COEF_B0: coef_b0 = $signed(value[COEF_W-1:0]);
      REG_COEF_B1: coef_b1 = $signed(value[COEF_W-1:0]);
      REG_COEF_B2: coef_b2 = $signed(value[COEF_W-1:0]);
      REG_COEF_A1: coef_a1 = $signed(value[COEF_W-1:0]);
      REG_COEF_A2: coef_a2 = $signed(value[COEF_W-1:0]);
      REG_MIX_WEIGHT: weight_q = value[WEIGHT_W-1:0];
      REG_FORM_MODE: form_q = value[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender holds off until every request is taken and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (!(samples_taken == samples_queued && !in_valid && expected_samples.size() == 0))
      @(negedge clk);
  endtask

  task automatic send(logic signed [SAMPLE_W-1:0] x);
    sample_backlog.push_back(x);
    samples_queued++;
  endtask

  task automatic random_config();
    int kind, a1, a2, lim, r;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // stable section so the history keeps meaningful values
      a2 = int'($urandom_range(0, 104000)) - 52000;
      lim = 65536 + a2 - 4000;
      a1 = int'($urandom_range(0, 2 * lim)) - lim;
      set_reg(REG_COEF_B0, int'($urandom_range(0, 65536)) - 32768);
      set_reg(REG_COEF_B1, int'($urandom_range(0, 65536)) - 32768);
      set_reg(REG_COEF_B2, int'($urandom_range(0, 65536)) - 32768);
      set_reg(REG_COEF_A1, a1);
      set_reg(REG_COEF_A2, a2);
    end else if (kind < 8) begin
      for (int i = 0; i < 5; i++) set_reg(CFG_IDX_W'(i), int'($urandom));
    end else if (kind == 8) begin
      for (int i = 0; i < 5; i++) set_reg(CFG_IDX_W'(i), extreme_coef());
    end
    r = $urandom_range(0, 9);
    if (r == 0) set_reg(REG_MIX_WEIGHT, 0);
    else if (r == 1) set_reg(REG_MIX_WEIGHT, 65536);
    else if (r == 2) set_reg(REG_MIX_WEIGHT, $urandom_range(65537, 131071));
    else if (r == 3) set_reg(REG_MIX_WEIGHT, int'($urandom));
    else set_reg(REG_MIX_WEIGHT, $urandom_range(0, 65536));
    r = $urandom_range(0, 9);
    if (r < 3) set_reg(REG_FORM_MODE, MODE_DF1);
    else if (r < 6) set_reg(REG_FORM_MODE, MODE_DF1_MIX);
    else if (r < 9) set_reg(REG_FORM_MODE, MODE_DF2T);
    else set_reg(REG_FORM_MODE, MODE_SPARE);
    if ($urandom_range(0, 4) == 0) set_reg(REG_UNUSED, int'($urandom));
  endtask

  initial begin : stimulus
    int sent, n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pass-through after reset, field extremes
    @(posedge clk);
    send(16'sh7fff);
    send(16'sh8000);
    send(16'sh0000);
    send(16'shffff);
    send(16'sh0001);

    // extreme coefficients: saturated output fed back
    wait_idle();
    set_reg(REG_COEF_B0, 524287);
    set_reg(REG_COEF_B1, -524288);
    set_reg(REG_COEF_B2, 524287);
    set_reg(REG_COEF_A1, -524288);
    set_reg(REG_COEF_A2, 524287);
    @(posedge clk);
    send(16'sh7fff);
    send(16'sh8000);
    send(16'sh7fff);

    // dropped write to the spare index, then the spare form code
    wait_idle();
    set_reg(REG_UNUSED, 20'hfffff);
    set_reg(REG_FORM_MODE, MODE_SPARE);
    @(posedge clk);
    send(16'sh8000);
    send(16'sh7fff);

    // crossfade: weight above one, zero weight, half weight
    wait_idle();
    set_reg(REG_COEF_B0, 65536);
    set_reg(REG_COEF_B1, 0);
    set_reg(REG_COEF_B2, 0);
    set_reg(REG_COEF_A1, 0);
    set_reg(REG_COEF_A2, 0);
    set_reg(REG_FORM_MODE, MODE_DF1_MIX);
    set_reg(REG_MIX_WEIGHT, 131071);
    @(posedge clk);
    send(16'sd1000);
    send(16'sh8000);
    wait_idle();
    set_reg(REG_MIX_WEIGHT, 0);
    @(posedge clk);
    send(16'sh7fff);
    send(-16'sd5);
    wait_idle();
    set_reg(REG_MIX_WEIGHT, 32768);
    set_reg(REG_COEF_B0, -524288);
    @(posedge clk);
    send(16'sh8000);
    send(16'sh7fff);

    // form 2 with large gains: state words saturate
    wait_idle();
    set_reg(REG_COEF_B0, 524287);
    set_reg(REG_COEF_B1, 524287);
    set_reg(REG_COEF_B2, -524288);
    set_reg(REG_COEF_A1, -524288);
    set_reg(REG_COEF_A2, 524287);
    set_reg(REG_FORM_MODE, MODE_DF2T);
    @(posedge clk);
    send(16'sh7fff);
    send(16'sh7fff);
    send(16'sh8000);
    send(16'sh7fff);

    // form change with live history, both ways
    wait_idle();
    set_reg(REG_FORM_MODE, MODE_DF1);
    @(posedge clk);
    send(16'sh0000);
    send(16'sh0000);
    wait_idle();
    set_reg(REG_FORM_MODE, MODE_DF2T);
    set_reg(REG_COEF_B0, 0);
    @(posedge clk);
    send(16'sh0000);

    // random bursts, each with its own setting
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      wait_idle();
      random_config();
      @(posedge clk);
      in_calm = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(60, 140);
      repeat (n) send(pick_sample());
      sent += n;
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #15000000;
    $display("tb: failure");
    $finish;
  end

endmodule
